### rtl/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg: shared constants for the lidar frame parser
// Frame layout, header byte and result field widths.
// ----------------------------------------------------------------------------
package lfsc_pkg;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int DIST_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int RESULT_W = 1 + DIST_W + COUNT_W;
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h59;

    // frame_pos codes: 0 hunts, otherwise index of the next frame byte
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_DLOW  = 4'd2;
    localparam logic [POS_W-1:0] POS_DHIGH = 4'd3;
    localparam logic [POS_W-1:0] POS_CHK   = 4'd8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [COUNT_W-1:0] bad_frames;
        logic [DIST_W-1:0]  distance_mm;
        logic               frame_ok;
    } result_t;

endpackage

### rtl/lidar_frame_sync_checksum_parser.sv
// ----------------------------------------------------------------------------
// lidar_frame_sync_checksum_parser
// Hunts for a double 0x59 header in a stream of sensor bytes, collects the
// rest of the 9-byte frame and emits checksum status, distance and a
// saturating bad-frame count once per frame.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit first)                     | per
//  ---------+-----+--------------------------------------------------+-------
//  s_       | in  | rx_byte[7:0]                                     | byte
//  m_       | out | frame_ok[0], distance_mm[16:1], bad_frames[32:17] | frame
//
//  One byte is taken every cycle unless the input stalls as below; the position counter and running sum
//  update in the same cycle the byte is accepted.
//  A result is loaded into the output register in the cycle after the checksum byte is accepted.
//  Input stalls only when a checksum byte arrives while the previous result
//  is still held and m_tready is low.
//  aresetn (synchronous) returns the parser to hunting with zero counts.
// ----------------------------------------------------------------------------
module lidar_frame_sync_checksum_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lfsc_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lfsc_pkg::M_DATA_W-1:0] m_tdata    // [0] frame_ok,
                                                     // [16:1] distance_mm,
                                                     // [32:17] bad_frames
);
    import lfsc_pkg::*;

    logic [POS_W-1:0]   frame_pos_reg, frame_pos_next;
    logic [BYTE_W-1:0]  prev_byte_reg, prev_byte_next;
    logic [BYTE_W-1:0]  run_sum_reg,   run_sum_next;
    logic [BYTE_W-1:0]  dist_low_reg,  dist_low_next;
    logic [BYTE_W-1:0]  dist_high_reg, dist_high_next;
    logic [COUNT_W-1:0] bad_count_reg, bad_count_next;
    logic               m_valid_reg,   m_valid_next;
    result_t            result_reg,    result_next;

    logic s_accept;
    logic is_chk;
    logic sum_ok;

    assign is_chk   = (frame_pos_reg >= POS_CHK);
    assign s_tready = !is_chk || !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign sum_ok   = (run_sum_reg == s_tdata);

    always_comb begin
        frame_pos_next = frame_pos_reg;
        prev_byte_next = prev_byte_reg;
        run_sum_next   = run_sum_reg;
        dist_low_next  = dist_low_reg;
        dist_high_next = dist_high_reg;
        bad_count_next = bad_count_reg;
        result_next    = result_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        if (s_accept) begin
            if (frame_pos_reg == POS_HUNT) begin
                if (s_tdata == HDR_BYTE && prev_byte_reg == HDR_BYTE) begin
                    frame_pos_next = POS_FIRST;
                    run_sum_next   = HDR_BYTE + HDR_BYTE;
                end
                prev_byte_next = s_tdata;
            end else if (!is_chk) begin
                if (frame_pos_reg == POS_DLOW) begin
                    dist_low_next = s_tdata;
                end else if (frame_pos_reg == POS_DHIGH) begin
                    dist_high_next = s_tdata;
                end
                run_sum_next   = run_sum_reg + s_tdata;
                frame_pos_next = frame_pos_reg + POS_W'(1);
            end else begin
                // close the frame and go back to hunting with a clean history
                if (!sum_ok && bad_count_reg != COUNT_MAX) begin
                    bad_count_next = bad_count_reg + COUNT_W'(1);
                end
                frame_pos_next         = POS_HUNT;
                prev_byte_next         = '0;
                result_next.frame_ok   = sum_ok;
                result_next.distance_mm = sum_ok ? {dist_high_reg, dist_low_reg}
                                                 : '0;
                result_next.bad_frames = bad_count_next;
                m_valid_next           = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= POS_HUNT;
            prev_byte_reg <= '0;
            run_sum_reg   <= '0;
            dist_low_reg  <= '0;
            dist_high_reg <= '0;
            bad_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            frame_pos_reg <= frame_pos_next;
            prev_byte_reg <= prev_byte_next;
            run_sum_reg   <= run_sum_next;
            dist_low_reg  <= dist_low_next;
            dist_high_reg <= dist_high_next;
            bad_count_reg <= bad_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, result_reg};

    // position only ever hunts or walks the data and checksum bytes
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_pos_reg != 4'd1 && frame_pos_reg <= POS_CHK)
        else $error("frame position out of range");

    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> bad_count_reg >= $past(bad_count_reg))
        else $error("bad-frame count went down");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept && is_chk))
        else $error("result without a checksum byte");

    a_bad_no_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !result_reg.frame_ok |-> result_reg.distance_mm == '0)
        else $error("rejected frame carries a distance");

    a_chk_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && is_chk |=> frame_pos_reg == POS_HUNT && prev_byte_reg == '0)
        else $error("parser did not return to hunting");

endmodule
